FILE: src/kwm_pkg.sv
// Shared types and constants for the k-way merge min-heap.
package kwm_pkg;

    localparam int ENTRIES_DEF = 16;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        K_INSERT  = 1'b0,
        K_EXTRACT = 1'b1
    } kind_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [3:0]  source;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] min_value;
        logic [3:0]  min_source;
        logic [4:0]  occupancy;
    } out_item_t;

    typedef struct packed {
        logic [31:0] key;
        logic [3:0]  src;
    } entry_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_ROOT,
        B_UP_RD,
        B_UP_CMP,
        B_DN_RD,
        B_DN_CMP,
        B_DONE
    } bstate_t;

endpackage

FILE: src/kwm_front.sv
// Front end: input skid queue of two entries feeding the heap engine.
module kwm_front
    import kwm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_data,
    output logic     q_valid,
    input  logic     q_take,
    output in_item_t q_data
);

    in_item_t  slot_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg;
    logic       wr_reg;

    wire push = in_valid && !in_stall;
    wire pop  = q_valid && q_take;

    assign in_stall = cnt_reg == 2'd2;
    assign q_valid  = cnt_reg != 2'd0;
    assign q_data   = slot_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push) wr_reg <= !wr_reg;
            if (pop)  rd_reg <= !rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

FILE: src/kwm_back.sv
// Back end: heap store and sift sequencer, with a registered result.
module kwm_back
    import kwm_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_take,
    input  in_item_t  q_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    entry_t mem [ENTRIES];
    entry_t rd_a_reg, rd_b_reg;

    bstate_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] pos_reg, pos_next;
    entry_t cur_reg, cur_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [AW-1:0] ra_addr, rb_addr, w_addr;
    entry_t w_data;
    logic w_en;
    logic [CW:0] lc, rc, par;
    logic l_ok, r_ok;
    logic [CW-1:0] pick;
    logic [31:0] pick_key;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (w_en)
        begin
            mem[w_addr] <= w_data;
        end
        rd_a_reg <= mem[ra_addr];
        rd_b_reg <= mem[rb_addr];
    end

    always_comb
    begin
        lc  = {pos_reg, 1'b1};
        rc  = {pos_reg, 1'b0} + {{CW{1'b0}}, 1'b1} + {{CW{1'b0}}, 1'b1};
        par = {1'b0, pos_reg} - {{CW{1'b0}}, 1'b1};
        par = par >> 1;
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        cur_next       = cur_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next       = out_reg;
        q_take   = 1'b0;
        ra_addr  = par[AW-1:0];
        rb_addr  = rc[AW-1:0];
        w_en     = 1'b0;
        w_addr   = pos_reg[AW-1:0];
        w_data   = cur_reg;
        l_ok = 1'b0;
        r_ok = 1'b0;
        pick = pos_reg;
        pick_key = cur_reg.key;
        unique case (state_reg)
            B_IDLE:
            begin
                if (q_valid && !out_valid_next)
                begin
                    q_take = 1'b1;
                    out_next = '0;
                    out_next.occupancy = 5'(count_reg);
                    if (q_data.kind == K_INSERT)
                    begin
                        if (count_reg == CW'(ENTRIES))
                        begin
                            out_next.status = ST_FULL;
                            state_next = B_DONE;
                        end
                        else
                        begin
                            cur_next   = '{key: q_data.value, src: q_data.source};
                            pos_next   = count_reg;
                            count_next = count_reg + 1'b1;
                            out_next.occupancy = 5'(count_reg + 1'b1);
                            state_next = B_UP_RD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_next.status = ST_EMPTY;
                        state_next = B_DONE;
                    end
                    else
                    begin
                        ra_addr    = '0;
                        rb_addr    = AW'(count_reg - 1'b1);
                        count_next = count_reg - 1'b1;
                        out_next.occupancy = 5'(count_reg - 1'b1);
                        state_next = B_ROOT;
                    end
                end
            end
            B_ROOT:
            begin
                out_next.min_value  = rd_a_reg.key;
                out_next.min_source = rd_a_reg.src;
                cur_next   = rd_b_reg;
                pos_next   = '0;
                state_next = (count_reg == '0) ? B_DONE : B_DN_RD;
            end
            B_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    w_en = 1'b1;
                    state_next = B_DONE;
                end
                else
                begin
                    state_next = B_UP_CMP;
                end
            end
            B_UP_CMP:
            begin
                if ($signed(rd_a_reg.key) > $signed(cur_reg.key))
                begin
                    w_en   = 1'b1;
                    w_data = rd_a_reg;
                    pos_next = par[CW-1:0];
                    state_next = B_UP_RD;
                end
                else
                begin
                    w_en = 1'b1;
                    state_next = B_DONE;
                end
            end
            B_DN_RD:
            begin
                ra_addr = lc[AW-1:0];
                state_next = B_DN_CMP;
            end
            B_DN_CMP:
            begin
                l_ok = (lc < {1'b0, count_reg}) &&
                       ($signed(rd_a_reg.key) < $signed(cur_reg.key));
                if (l_ok)
                begin
                    pick = lc[CW-1:0];
                    pick_key = rd_a_reg.key;
                end
                r_ok = (rc < {1'b0, count_reg}) &&
                       ($signed(rd_b_reg.key) < $signed(pick_key));
                if (r_ok) pick = rc[CW-1:0];
                w_en = 1'b1;
                if (!l_ok && !r_ok)
                begin
                    state_next = B_DONE;
                end
                else
                begin
                    w_data   = r_ok ? rd_b_reg : rd_a_reg;
                    pos_next = pick;
                    state_next = B_DN_RD;
                end
            end
            B_DONE:
            begin
                out_valid_next = 1'b1;
                state_next = B_IDLE;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        cur_reg <= cur_next;
        pos_reg <= pos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: src/kway_merge_min_heap.sv
// Top level of the k-way merge min-heap engine.
// A binary min-heap of ENTRIES entries, each a signed 32-bit key tagged with a
// 4-bit source list index. Insert (kind 0) appends and sifts up; extract
// (kind 1) returns the root and sifts the last entry down, picking the left
// child if strictly smaller, then the right child if strictly smaller than
// that. Extract on empty reports status 1, insert into a full heap is dropped
// with status 2. Every transfer in yields exactly one result transfer out.
// A two-entry input queue decouples the front from the heap sequencer. The
// sequencer starts a new item only when the result register is empty or its
// result is taken in that same cycle, so a stalled result holds the engine.
// Each heap level visited costs one registered memory read and one
// compare/write. Items pass through the registered input queue before they
// reach the engine.
module kway_merge_min_heap
    import kwm_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    logic     q_valid;
    logic     q_take;
    in_item_t q_data;

    // front: accepts and queues items
    kwm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_take   (q_take),
        .q_data   (q_data)
    );

    // back: heap store and sift sequencer
    kwm_back #(.ENTRIES(ENTRIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_take    (q_take),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // occupancy never exceeds capacity
    a_occ: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.occupancy) <= ENTRIES))
        else $error("occupancy out of range");

    // a dropped or empty result carries no entry
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.min_value == '0 && out_data.min_source == '0)
        else $error("nonzero payload on error status");

endmodule
